// ===== rtl/core/swsl_pkg.sv =====
// ----------------------------------------------------------------------------
// swsl_pkg
// Shared types and constants of the square-wave sync lock core.
// ----------------------------------------------------------------------------
package swsl_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MASTER   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_PERIOD   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_TOL      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_REQUIRED = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDX_BURST    = 3'd4;

  localparam int unsigned CfgDataW = 8;

  // Register reset values.
  localparam logic [7:0] PERIOD_RST   = 8'd35;
  localparam logic [4:0] TOL_RST      = 5'd2;
  localparam logic [6:0] REQUIRED_RST = 7'd31;
  localparam logic [6:0] BURST_RST    = 7'd31;

  // Phase codes as seen on the result port.
  localparam logic [1:0] PHASE_CODE_HUNT  = 2'd0;
  localparam logic [1:0] PHASE_CODE_BURST = 2'd1;
  localparam logic [1:0] PHASE_CODE_DONE  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_BURST = 3'b010,
    PH_DONE  = 3'b100
  } phase_e;

  typedef struct packed {
    logic       master_mode;
    logic [7:0] nominal_period;
    logic [4:0] tolerance;
    logic [6:0] required_runs;
    logic [6:0] burst_toggles;
  } cfg_t;

  typedef struct packed {
    logic       have_level;
    logic       prev_level;
    logic [7:0] run_length;
    logic       run_overlong;
    logic [6:0] good_runs;
    logic       drive_level;
    logic [7:0] tick_count;
    logic [6:0] toggles_left;
    phase_e     phase;
  } state_t;

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_HUNT:  code = PHASE_CODE_HUNT;
      PH_BURST: code = PHASE_CODE_BURST;
      PH_DONE:  code = PHASE_CODE_DONE;
      default:  code = PHASE_CODE_HUNT;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/swsl_cfg.sv =====
// ----------------------------------------------------------------------------
// swsl_cfg
// Configuration register bank, written one register per handshake.
// ----------------------------------------------------------------------------
module swsl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swsl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [swsl_pkg::CfgDataW-1:0]  cfg_data_i,
  output swsl_pkg::cfg_t                 cfg_o
);
  import swsl_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_MASTER:   cfg_d.master_mode    = cfg_data_i[0];
        CFG_IDX_PERIOD:   cfg_d.nominal_period = cfg_data_i[7:0];
        CFG_IDX_TOL:      cfg_d.tolerance      = cfg_data_i[4:0];
        CFG_IDX_REQUIRED: cfg_d.required_runs  = cfg_data_i[6:0];
        CFG_IDX_BURST:    cfg_d.burst_toggles  = cfg_data_i[6:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_mode    <= 1'b0;
      cfg_q.nominal_period <= PERIOD_RST;
      cfg_q.tolerance      <= TOL_RST;
      cfg_q.required_runs  <= REQUIRED_RST;
      cfg_q.burst_toggles  <= BURST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/swsl_step.sv =====
// ----------------------------------------------------------------------------
// swsl_step
// Next-state logic for one tick: run measurement, lock detection and the
// output toggle generator.
// ----------------------------------------------------------------------------
module swsl_step (
  input  swsl_pkg::cfg_t   cfg_i,
  input  swsl_pkg::state_t state_i,
  input  logic             level_i,
  output swsl_pkg::state_t state_o
);
  import swsl_pkg::*;

  logic [7:0] eff_period;
  logic [8:0] hi_bound;
  logic [7:0] lo_bound;
  logic [6:0] need;
  logic [7:0] tick_inc;
  logic       tick_due;
  logic       same_level;
  logic       run_good;
  logic [6:0] good_inc;
  logic [8:0] run_inc;

  always_comb begin
    eff_period = (cfg_i.nominal_period == 8'd0) ? 8'd1 : cfg_i.nominal_period;
    hi_bound   = {1'b0, cfg_i.nominal_period} + {4'd0, cfg_i.tolerance};
    lo_bound   = (cfg_i.nominal_period > {3'd0, cfg_i.tolerance})
               ? (cfg_i.nominal_period - {3'd0, cfg_i.tolerance}) : 8'd1;
    need       = (cfg_i.required_runs == 7'd0) ? 7'd1 : cfg_i.required_runs;
    tick_inc   = state_i.tick_count + 8'd1;
    tick_due   = (tick_inc >= eff_period);
    same_level = state_i.have_level && (level_i == state_i.prev_level);
    run_inc    = {1'b0, state_i.run_length} + 9'd1;
    run_good   = state_i.have_level && !state_i.run_overlong
               && (state_i.run_length >= lo_bound)
               && ({1'b0, state_i.run_length} <= hi_bound);
    good_inc   = state_i.good_runs + 7'd1;
  end

  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      PH_HUNT: begin
        if (same_level) begin
          if (!state_i.run_overlong) begin
            if (state_i.run_length == 8'hFF || run_inc > hi_bound) begin
              state_o.run_overlong = 1'b1;
            end else begin
              state_o.run_length = run_inc[7:0];
            end
          end
        end else begin
          state_o.run_length   = 8'd1;
          state_o.run_overlong = 1'b0;
          state_o.good_runs    = run_good ? good_inc : 7'd0;
        end
        state_o.prev_level = level_i;
        state_o.have_level = 1'b1;

        if (!same_level && run_good && good_inc >= need) begin
          // Lock: the run counters keep their old values and the master
          // output does not toggle on this tick.
          state_o.run_length   = state_i.run_length;
          state_o.run_overlong = state_i.run_overlong;
          if (cfg_i.master_mode) begin
            state_o.phase = PH_DONE;
          end else begin
            state_o.drive_level  = 1'b1;
            state_o.tick_count   = 8'd0;
            state_o.toggles_left = cfg_i.burst_toggles;
            state_o.phase = (cfg_i.burst_toggles != 7'd0) ? PH_BURST : PH_DONE;
          end
        end else if (cfg_i.master_mode) begin
          state_o.tick_count = tick_due ? 8'd0 : tick_inc;
          if (tick_due) begin
            state_o.drive_level = !state_i.drive_level;
          end
        end
      end
      PH_BURST: begin
        state_o.tick_count = tick_due ? 8'd0 : tick_inc;
        if (tick_due) begin
          state_o.drive_level  = !state_i.drive_level;
          state_o.toggles_left = state_i.toggles_left - 7'd1;
          if (state_i.toggles_left == 7'd1) begin
            state_o.phase = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== rtl/core/square_wave_sync_lock_core.sv =====
// ----------------------------------------------------------------------------
// square_wave_sync_lock_core
// Sync line lock detector with master toggle and slave burst generation.
// ----------------------------------------------------------------------------
// An accepted item is captured in the input register; the state is updated
// as it moves on to the result register, which offers its result. Throughput:
// one item per cycle unless out_ready_i stalls the result register; the single
// state update per tick is the only loop. Reset clears the valid flags and
// the lock state, loads the configuration defaults; no clearing pass is needed.
module square_wave_sync_lock_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swsl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [swsl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           pin_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_level_o,
  output logic [1:0]                     phase_o,
  output logic [6:0]                     good_run_count_o
);
  import swsl_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d;

  logic       in_valid_q;
  logic       in_level_q;
  logic       out_valid_q;
  logic       out_level_q;
  logic [1:0] out_phase_q;
  logic [6:0] out_count_q;
  logic       advance;

  swsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swsl_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .level_i (in_level_q),
    .state_o (state_d)
  );

  // The item in the input register moves on whenever the result register is
  // empty or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_HUNT, default: '0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_level_q <= pin_level_i;
    end
    if (advance) begin
      out_level_q <= state_d.drive_level;
      out_phase_q <= phase_code(state_d.phase);
      out_count_q <= state_d.good_runs;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_level_o      = out_level_q;
  assign phase_o          = out_phase_q;
  assign good_run_count_o = out_count_q;

endmodule
